// File: hdl/locd_pkg.sv
// Package for the lock-order cycle detector: field layout, defaults,
// sequencer state type and the command struct of the order matrix.
// No dependencies.
`timescale 1ns / 1ps

package locd_pkg;

    // Default sizes handed to the top level
    localparam int DEF_NUM_LOCKS   = 16;
    localparam int DEF_NUM_THREADS = 8;

    // Input transaction layout (lowest bit first): action, thread_id, lock_id
    localparam int ACTION_W    = 1;
    localparam int TID_W       = 3;
    localparam int LID_W       = 4;
    localparam int ACTION_LSB  = 0;
    localparam int TID_LSB     = ACTION_LSB + ACTION_W;
    localparam int LID_LSB     = TID_LSB + TID_W;
    localparam int IN_TDATA_W  = 8;

    // Result transaction layout (lowest bit first): checked, cycle_found, cycle_lock
    localparam int CLOCK_W     = 4;
    localparam int OUT_FIELD_W = 2 + CLOCK_W;
    localparam int OUT_TDATA_W = 8;

    // Range checks are done at this width (covers indices and counts up to 127)
    localparam int CMP_W       = 7;

    // Action codes
    localparam logic [ACTION_W-1:0] ACTION_ACQUIRE = 1'b0;
    localparam logic [ACTION_W-1:0] ACTION_RELEASE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_CLOSE,
        ST_SCAN,
        ST_DONE
    } locd_state_t;

    // Commands from the sequencer to the order matrix
    typedef struct packed {
        logic add_edges;
        logic close_step;
    } locd_mcmd_t;

endpackage

// File: hdl/locd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module locd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/locd_matrix.sv
// Order matrix of the cycle detector: one register row per lock, edge
// insertion and one Warshall step (all rows at once) per cycle.
// Depends on locd_pkg.
`timescale 1ns / 1ps

module locd_matrix #(
    parameter int NUM_LOCKS = locd_pkg::DEF_NUM_LOCKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  locd_pkg::locd_mcmd_t          mcmd,
    input  logic [NUM_LOCKS-1:0]          held,
    input  logic [NUM_LOCKS-1:0]          lock_bit,
    input  logic [$clog2(NUM_LOCKS)-1:0]  k,
    output logic                          new_edge,
    output logic [NUM_LOCKS-1:0]          diag
);

    import locd_pkg::*;

    logic [NUM_LOCKS-1:0] rows_reg  [NUM_LOCKS];
    logic [NUM_LOCKS-1:0] rows_next [NUM_LOCKS];
    logic [NUM_LOCKS-1:0] via;
    logic [NUM_LOCKS-1:0] need;

    // Add edges from held locks, or relax every row through lock k
    always_comb
    begin
        via = rows_reg[k];
        for (int i = 0; i < NUM_LOCKS; i++)
        begin
            need[i]      = held[i] & ~(|(rows_reg[i] & lock_bit));
            diag[i]      = rows_reg[i][i];
            rows_next[i] = rows_reg[i];
            if (mcmd.add_edges && held[i])
            begin
                rows_next[i] = rows_reg[i] | lock_bit;
            end
            else if (mcmd.close_step && rows_reg[i][k])
            begin
                rows_next[i] = rows_reg[i] | via;
            end
        end
    end

    assign new_edge = |need;

    // Hold the rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                rows_reg[i] <= rows_next[i];
            end
        end
    end

endmodule

// File: hdl/locd_ctrl.sv
// Sequencer of the cycle detector: input capture, held-set update,
// closure and self-loop scan stepping, cached cycle result and output register.
// Depends on locd_pkg.
`timescale 1ns / 1ps

module locd_ctrl #(
    parameter int NUM_LOCKS   = locd_pkg::DEF_NUM_LOCKS,
    parameter int NUM_THREADS = locd_pkg::DEF_NUM_THREADS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [locd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [locd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 ram_rd_en,
    output logic [((NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1)-1:0] ram_rd_addr,
    input  logic [NUM_LOCKS-1:0]                 ram_rd_data,
    output logic                                 ram_wr_en,
    output logic [((NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1)-1:0] ram_wr_addr,
    output logic [NUM_LOCKS-1:0]                 ram_wr_data,
    output locd_pkg::locd_mcmd_t                 mcmd,
    output logic [NUM_LOCKS-1:0]                 held,
    output logic [NUM_LOCKS-1:0]                 lock_bit,
    output logic [$clog2(NUM_LOCKS)-1:0]         k,
    input  logic                                 new_edge,
    input  logic [NUM_LOCKS-1:0]                 diag
);

    import locd_pkg::*;

    localparam int LIDX_W = $clog2(NUM_LOCKS);
    localparam int TIDX_W = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam logic [LIDX_W-1:0] K_LAST = LIDX_W'(NUM_LOCKS - 1);
    localparam logic [NUM_LOCKS-1:0] ONE_LOCK = {{(NUM_LOCKS-1){1'b0}}, 1'b1};

    locd_state_t             state_reg, state_next;
    logic [ACTION_W-1:0]     action_reg, action_next;
    logic [TIDX_W-1:0]       tid_reg, tid_next;
    logic                    range_reg, range_next;
    logic [NUM_LOCKS-1:0]    lock_bit_reg, lock_bit_next;
    logic                    checked_reg, checked_next;
    logic [LIDX_W-1:0]       k_reg, k_next;
    logic                    cyc_found_reg, cyc_found_next;
    logic [CLOCK_W-1:0]      cyc_lock_reg, cyc_lock_next;
    logic [NUM_THREADS-1:0]  hvalid_reg, hvalid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic                    in_fire;
    logic [TID_W-1:0]        tid_in;
    logic [LID_W-1:0]        lid_in;
    logic                    acquire;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign tid_in  = s_axis_tdata[TID_LSB +: TID_W];
    assign lid_in  = s_axis_tdata[LID_LSB +: LID_W];
    assign acquire = (action_reg == ACTION_ACQUIRE);

    // Fetch the thread's held set as the transaction is taken
    assign ram_rd_en   = in_fire;
    assign ram_rd_addr = TIDX_W'(tid_in);
    assign ram_wr_addr = tid_reg;

    // An unwritten held row reads as empty
    assign held     = (range_reg && hvalid_reg[tid_reg]) ? ram_rd_data : '0;
    assign lock_bit = lock_bit_reg;
    assign k        = k_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        tid_next        = tid_reg;
        range_next      = range_reg;
        lock_bit_next   = lock_bit_reg;
        checked_next    = checked_reg;
        k_next          = k_reg;
        cyc_found_next  = cyc_found_reg;
        cyc_lock_next   = cyc_lock_reg;
        hvalid_next     = hvalid_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        ram_wr_en       = 1'b0;
        ram_wr_data     = held;
        mcmd.add_edges  = 1'b0;
        mcmd.close_step = 1'b0;

        // Drop the result once the receiver takes it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    action_next   = s_axis_tdata[ACTION_LSB +: ACTION_W];
                    tid_next      = TIDX_W'(tid_in);
                    range_next    = (CMP_W'(tid_in) < CMP_W'(NUM_THREADS)) &&
                                    (CMP_W'(lid_in) < CMP_W'(NUM_LOCKS));
                    lock_bit_next = ONE_LOCK << lid_in;
                    state_next    = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                checked_next = 1'b0;
                k_next       = '0;
                if (range_reg)
                begin
                    ram_wr_en            = 1'b1;
                    hvalid_next[tid_reg] = 1'b1;
                    if (acquire)
                    begin
                        ram_wr_data    = held | lock_bit_reg;
                        mcmd.add_edges = 1'b1;
                        checked_next   = new_edge;
                    end
                    else
                    begin
                        ram_wr_data = held & ~lock_bit_reg;
                    end
                end
                state_next = (range_reg && acquire && new_edge) ? ST_CLOSE : ST_DONE;
            end
            ST_CLOSE:
            begin
                mcmd.close_step = 1'b1;
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                // Search for the lowest lock with a self edge
                if (diag[k_reg])
                begin
                    cyc_found_next = 1'b1;
                    cyc_lock_next  = CLOCK_W'(k_reg);
                    state_next     = ST_DONE;
                end
                else if (k_reg == K_LAST)
                begin
                    cyc_found_next = 1'b0;
                    cyc_lock_next  = '0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
                                      cyc_lock_reg, cyc_found_reg, checked_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            cyc_found_reg <= 1'b0;
            cyc_lock_reg  <= '0;
            hvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cyc_found_reg <= cyc_found_next;
            cyc_lock_reg  <= cyc_lock_next;
            hvalid_reg    <= hvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        tid_reg      <= tid_next;
        range_reg    <= range_next;
        lock_bit_reg <= lock_bit_next;
        checked_reg  <= checked_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: hdl/lock_order_cycle_detector.sv
// Top level of the lock-order cycle detector: held-set RAM, order matrix
// and sequencer. Depends on locd_pkg, locd_ram, locd_matrix and locd_ctrl.
`timescale 1ns / 1ps

// Usage
//   s_axis carries one lock or unlock event per transaction; m_axis returns
//   one result transaction for each event, in order.
//   An event is taken only while s_axis_tready is high, one at a time.
//   Sequence: an unlock, an out-of-range event, or a lock that adds no new
//   ordering edge goes from acceptance through the edge and done states to
//   m_axis_tvalid. A lock that adds an edge first reruns the transitive
//   closure, one intermediate lock per cycle over all matrix rows, then
//   scans the diagonal one lock per cycle up to the first self edge.
//   Events are not overlapped; the next event is taken in the cycle its
//   predecessor's result appears.
//   The result sits in an output register; the next event may be taken and
//   worked on while it waits. If m_axis_tready stays low, the block halts
//   with the newer result ready and s_axis_tready low until the old one goes.
//   Reset clears the order matrix, the held-set valid bits, the cached cycle
//   result and the output valid flag; the block takes events from the first
//   cycle after reset.
module lock_order_cycle_detector #(
    parameter int NUM_LOCKS   = locd_pkg::DEF_NUM_LOCKS,
    parameter int NUM_THREADS = locd_pkg::DEF_NUM_THREADS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // action [0], thread_id [3:1], lock_id [7:4]
    input  logic [locd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // checked [0], cycle_found [1], cycle_lock [5:2], zero [7:6]
    output logic [locd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import locd_pkg::*;

    localparam int LIDX_W = $clog2(NUM_LOCKS);
    localparam int TIDX_W = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

    logic                   ram_rd_en;
    logic [TIDX_W-1:0]      ram_rd_addr;
    logic [NUM_LOCKS-1:0]   ram_rd_data;
    logic                   ram_wr_en;
    logic [TIDX_W-1:0]      ram_wr_addr;
    logic [NUM_LOCKS-1:0]   ram_wr_data;
    locd_mcmd_t             mcmd;
    logic [NUM_LOCKS-1:0]   held;
    logic [NUM_LOCKS-1:0]   lock_bit;
    logic [LIDX_W-1:0]      k;
    logic                   new_edge;
    logic [NUM_LOCKS-1:0]   diag;

    // Held locks per thread
    locd_ram #(
        .WIDTH (NUM_LOCKS),
        .DEPTH (NUM_THREADS)
    ) u_held_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Ordering edges and closure unit
    locd_matrix #(
        .NUM_LOCKS (NUM_LOCKS)
    ) u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .mcmd     (mcmd),
        .held     (held),
        .lock_bit (lock_bit),
        .k        (k),
        .new_edge (new_edge),
        .diag     (diag)
    );

    // Sequencer and output register
    locd_ctrl #(
        .NUM_LOCKS   (NUM_LOCKS),
        .NUM_THREADS (NUM_THREADS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .mcmd          (mcmd),
        .held          (held),
        .lock_bit      (lock_bit),
        .k             (k),
        .new_edge      (new_edge),
        .diag          (diag)
    );

endmodule

// File: hdl/locd_checker.sv
// Port-level checker for the lock-order cycle detector, bound to the top level.
// Depends on locd_pkg and lock_order_cycle_detector.
`timescale 1ns / 1ps

module locd_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [locd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [locd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import locd_pkg::*;

    // Hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

    // One event at a time: busy right after an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second event taken while the first is in work");

    // A new result only appears from the busy sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result presented without an event in work");

    // No cycle means cycle_lock reads zero, and the pad bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1] || m_axis_tdata[5:2] == 4'd0) &&
                          m_axis_tdata[7:6] == 2'd0)
    else $error("cycle_lock set without a cycle, or pad bits set");

endmodule

bind lock_order_cycle_detector locd_checker u_locd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: verif/lock_order_cycle_detector_tb.sv
// Self-checking testbench for lock_order_cycle_detector: directed table, then
// ordered and disordered random lock traffic under several idling phases.
// Depends on locd_pkg and the lock_order_cycle_detector RTL.
`timescale 1ns / 1ps

module lock_order_cycle_detector_tb;

    import locd_pkg::*;

    localparam int NUM_LOCKS      = DEF_NUM_LOCKS;
    localparam int NUM_THREADS    = DEF_NUM_THREADS;
    localparam int PHASE_ITEMS    = 440;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 3 + 2 * NUM_LOCKS + 8;
    localparam int DIR_ROWS       = 25;
    // marks a table row whose result comes from the predictor
    localparam int PRED           = -1;

    typedef struct packed {
        logic       checked;
        logic       cycle_found;
        logic [3:0] cycle_lock;
    } cycle_report_t;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [TID_W-1:0]    tid;
        logic [LID_W-1:0]    lid;
        logic                typed;
        cycle_report_t       report;
    } event_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // predictor state: ordering edges and per-thread held locks
    logic [NUM_LOCKS-1:0]   order_rows [NUM_LOCKS] = '{default: '0};
    logic [NUM_LOCKS-1:0]   held_rows [NUM_THREADS] = '{default: '0};

    cycle_report_t          pending_reports [$];
    cycle_report_t          want;
    int                     fail_count = 0;
    int                     send_idle_pct = 0;
    int                     stall_pct = 0;
    int                     quiet_cycles = 0;

    lock_order_cycle_detector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Apply one lock event to the predictor state and return its report
    function automatic cycle_report_t apply_lock_event(input logic [ACTION_W-1:0] act,
                                                       input logic [TID_W-1:0] tid,
                                                       input logic [LID_W-1:0] lid);
        cycle_report_t rep;
        logic          grew;
        rep  = '0;
        grew = 1'b0;
        if (int'(tid) < NUM_THREADS && int'(lid) < NUM_LOCKS)
        begin
            if (act == ACTION_ACQUIRE)
            begin
                // add an edge from every held lock to the new one
                for (int h = 0; h < NUM_LOCKS; h++)
                begin
                    if (held_rows[tid][h] && !order_rows[h][lid])
                    begin
                        order_rows[h][lid] = 1'b1;
                        grew = 1'b1;
                    end
                end
                // rerun the transitive closure when anything changed
                if (grew)
                begin
                    for (int k = 0; k < NUM_LOCKS; k++)
                    begin
                        for (int i = 0; i < NUM_LOCKS; i++)
                        begin
                            if (order_rows[i][k])
                                order_rows[i] = order_rows[i] | order_rows[k];
                        end
                    end
                end
                held_rows[tid][lid] = 1'b1;
            end
            else
            begin
                held_rows[tid][lid] = 1'b0;
            end
        end
        rep.checked = grew;
        // lowest lock with a self edge wins
        for (int i = NUM_LOCKS - 1; i >= 0; i--)
        begin
            if (order_rows[i][i])
            begin
                rep.cycle_found = 1'b1;
                rep.cycle_lock  = 4'(i);
            end
        end
        return rep;
    endfunction

    function automatic event_row_t make_row(input logic [ACTION_W-1:0] act, input int tid,
                                            input int lid, input int chk, input int fnd,
                                            input int lck);
        event_row_t row;
        row.act    = act;
        row.tid    = TID_W'(tid);
        row.lid    = LID_W'(lid);
        row.typed  = (chk != PRED);
        row.report = '{checked: 1'(chk), cycle_found: 1'(fnd), cycle_lock: 4'(lck)};
        return row;
    endfunction

    // Drive one event transaction and record its expected report on acceptance
    task automatic send_event(input logic [ACTION_W-1:0] act, input logic [TID_W-1:0] tid,
                              input logic [LID_W-1:0] lid, input logic typed,
                              input cycle_report_t report);
        cycle_report_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lid, tid, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = apply_lock_event(act, tid, lid);
        pending_reports.push_back(typed ? report : pred);
        @(negedge clk);
    endtask

    // Pick the next random event: mostly ordered acquires and releases
    task automatic pick_event(input int phase, output logic [ACTION_W-1:0] act,
                              output logic [TID_W-1:0] tid, output logic [LID_W-1:0] lid);
        int                   roll;
        int                   maxh;
        int                   span;
        logic [NUM_LOCKS-1:0] held;
        roll = $urandom_range(99);
        tid  = TID_W'($urandom_range(NUM_THREADS - 1));
        held = held_rows[tid];
        maxh = -1;
        for (int j = 0; j < NUM_LOCKS; j++)
        begin
            if (held[j])
                maxh = j;
        end
        if (roll < 5)
        begin
            // stray release, often of a lock not held
            act = ACTION_RELEASE;
            lid = LID_W'($urandom_range(NUM_LOCKS - 1));
        end
        else if (phase >= 2 && roll < 8)
        begin
            act = ACTION_W'($urandom_range(1));
            lid = LID_W'($urandom_range(NUM_LOCKS - 1));
        end
        else if (phase >= 2 && roll < 11 && maxh >= 0)
        begin
            // order inversion or re-acquire of a held lock
            act = ACTION_ACQUIRE;
            lid = LID_W'($urandom_range(maxh));
        end
        else if (maxh < NUM_LOCKS - 1 && (held == '0 || $urandom_range(99) < 55))
        begin
            // acquire above every held lock, keeping the order acyclic
            act = ACTION_ACQUIRE;
            if ($urandom_range(1) == 1)
            begin
                lid = LID_W'($urandom_range(NUM_LOCKS - 1, maxh + 1));
            end
            else
            begin
                span = NUM_LOCKS - 2 - maxh;
                if (span > 3)
                    span = 3;
                lid = LID_W'(maxh + 1 + $urandom_range(span));
            end
        end
        else
        begin
            act = ACTION_RELEASE;
            do
                lid = LID_W'($urandom_range(NUM_LOCKS - 1));
            while (!held[lid]);
        end
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            fail_count++;
        end
    endtask

    // Stall the result side at random
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual tdata=%h", $time,
                         m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("checked", int'(want.checked), int'(m_axis_tdata[0]));
                check_field("cycle_found", int'(want.cycle_found), int'(m_axis_tdata[1]));
                check_field("cycle_lock", int'(want.cycle_lock), int'(m_axis_tdata[5:2]));
                check_field("padding", 0, int'(m_axis_tdata[7:6]));
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        event_row_t            dir_rows [DIR_ROWS];
        logic [ACTION_W-1:0]   act;
        logic [TID_W-1:0]      tid;
        logic [LID_W-1:0]      lid;

        // directed events; all ordering edges point upwards until the re-acquire
        dir_rows[0]  = make_row(ACTION_RELEASE, 0, 0, 0, 0, 0);
        dir_rows[1]  = make_row(ACTION_ACQUIRE, 0, 0, 0, 0, 0);
        dir_rows[2]  = make_row(ACTION_ACQUIRE, 0, 1, 1, 0, 0);
        dir_rows[3]  = make_row(ACTION_RELEASE, 0, 1, 0, 0, 0);
        dir_rows[4]  = make_row(ACTION_ACQUIRE, 0, 1, 0, 0, 0);
        dir_rows[5]  = make_row(ACTION_RELEASE, 0, 1, PRED, 0, 0);
        dir_rows[6]  = make_row(ACTION_RELEASE, 0, 0, PRED, 0, 0);
        dir_rows[7]  = make_row(ACTION_ACQUIRE, 7, 15, 0, 0, 0);
        dir_rows[8]  = make_row(ACTION_ACQUIRE, 3, 5, PRED, 0, 0);
        dir_rows[9]  = make_row(ACTION_ACQUIRE, 3, 9, 1, 0, 0);
        dir_rows[10] = make_row(ACTION_ACQUIRE, 3, 12, PRED, 0, 0);
        dir_rows[11] = make_row(ACTION_RELEASE, 3, 9, PRED, 0, 0);
        dir_rows[12] = make_row(ACTION_RELEASE, 3, 5, PRED, 0, 0);
        dir_rows[13] = make_row(ACTION_RELEASE, 3, 12, PRED, 0, 0);
        dir_rows[14] = make_row(ACTION_ACQUIRE, 2, 2, PRED, 0, 0);
        dir_rows[15] = make_row(ACTION_ACQUIRE, 2, 15, 1, 0, 0);
        dir_rows[16] = make_row(ACTION_RELEASE, 2, 15, PRED, 0, 0);
        dir_rows[17] = make_row(ACTION_RELEASE, 2, 2, PRED, 0, 0);
        dir_rows[18] = make_row(ACTION_ACQUIRE, 4, 1, PRED, 0, 0);
        // closure through an existing edge
        dir_rows[19] = make_row(ACTION_ACQUIRE, 4, 5, PRED, 0, 0);
        dir_rows[20] = make_row(ACTION_RELEASE, 4, 5, PRED, 0, 0);
        dir_rows[21] = make_row(ACTION_RELEASE, 4, 1, PRED, 0, 0);
        // re-acquiring a held lock puts it on a cycle
        dir_rows[22] = make_row(ACTION_ACQUIRE, 7, 15, 1, 1, 15);
        dir_rows[23] = make_row(ACTION_RELEASE, 7, 15, 0, 1, 15);
        dir_rows[24] = make_row(ACTION_ACQUIRE, 6, 15, PRED, 0, 0);

        // hold reset low, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
            send_event(dir_rows[r].act, dir_rows[r].tid, dir_rows[r].lid, dir_rows[r].typed,
                       dir_rows[r].report);

        // random traffic: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 48 : (phase == 3) ? 31 : 0;
            stall_pct     = (phase == 2) ? 48 : (phase == 3) ? 31 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_event(phase, act, tid, lid);
                send_event(act, tid, lid, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
hdl/locd_pkg.sv
hdl/locd_ram.sv
hdl/locd_matrix.sv
hdl/locd_ctrl.sv
hdl/lock_order_cycle_detector.sv
hdl/locd_checker.sv
verif/lock_order_cycle_detector_tb.sv
